// ===== src/icrc_pkg.sv =====
// ----------------------------------------------------------------------------
// icrc_pkg
// Shared types, constants and CRC helper functions of the RoCEv2 ICRC unit.
// ----------------------------------------------------------------------------
package icrc_pkg;

   localparam int WORD_BITS           = 64;
   localparam int BYTE_BITS           = 8;
   localparam int LANES               = WORD_BITS / BYTE_BITS;
   localparam int CRC_BITS            = 32;
   localparam int CNT_BITS            = $clog2(LANES + 1);
   localparam int IDX_BITS            = 3;
   localparam int HEADER_WORDS        = 7;
   localparam int HEADER_BITS_DEFAULT = 424;

   typedef logic [CRC_BITS-1:0]  crc_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [LANES-1:0]     enable_type;
   typedef logic [CNT_BITS-1:0]  count_type;
   typedef logic [IDX_BITS-1:0]  index_type;

   localparam crc_type   CRC_POLY  = 32'hEDB88320;
   localparam crc_type   CRC_START = 32'hDEBB20E3;
   localparam index_type IDX_MAX   = 3'd7;

   // invariant fields per header word, word 0 in the lowest slot
   typedef logic [HEADER_WORDS-1:0][WORD_BITS-1:0] inv_table_type;
   localparam inv_table_type INV_MASK = {
      64'h000000FF00000000,
      64'hFFFF000000000000,
      64'h0000000000000000,
      64'h0000000000000000,
      64'h0000000000000000,
      64'h0000000000000000,
      64'hFF000000FFFFFF0F
   };

   // column j of entry n: unit vector j after n zero bytes through the crc
   typedef logic [LANES:0][CRC_BITS-1:0][CRC_BITS-1:0] shift_table_type;

   typedef struct packed {
      logic      fire;
      logic      last;
      count_type count;
   } icrc_ctl_type;

   function automatic shift_table_type build_shift_table();
      shift_table_type tab;
      crc_type         x;
      tab = '0;
      for (int n = 0; n <= LANES; n++) begin
         for (int j = 0; j < CRC_BITS; j++) begin
            x = crc_type'(1) << j;
            for (int s = 0; s < n * BYTE_BITS; s++) begin
               x = (x >> 1) ^ (x[0] ? CRC_POLY : '0);
            end
            tab[n][j] = x;
         end
      end
      return tab;
   endfunction

   localparam shift_table_type SHIFT_TABLE = build_shift_table();

   // advance a crc value by nbytes zero bytes (linear map, xor of columns)
   function automatic crc_type crc_shift(crc_type x, count_type nbytes);
      crc_type r;
      r = '0;
      if (nbytes <= count_type'(LANES)) begin
         for (int j = 0; j < CRC_BITS; j++) begin
            if (x[j]) begin
               r = r ^ SHIFT_TABLE[nbytes][j];
            end
         end
      end
      return r;
   endfunction

   // ones over the invariant fields of header word idx, cut at header_bits
   function automatic word_type header_mask(index_type idx, int header_bits);
      word_type m;
      m = '0;
      if (int'(idx) < HEADER_WORDS) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            if (int'(idx) * WORD_BITS + j < header_bits) begin
               m[j] = INV_MASK[idx][j];
            end
         end
      end
      return m;
   endfunction

endpackage

// ===== src/icrc_req_if.sv =====
// ----------------------------------------------------------------------------
// icrc_req_if
// Packet word channel: one 64-bit word with byte enables and end flag.
// ----------------------------------------------------------------------------
interface icrc_req_if;
   import icrc_pkg::*;

   logic       valid;
   logic       ready;
   word_type   data_bytes;
   enable_type byte_enable;
   logic       end_of_packet;

   modport source (
      output valid,
      output data_bytes,
      output byte_enable,
      output end_of_packet,
      input  ready
   );

   modport sink (
      input  valid,
      input  data_bytes,
      input  byte_enable,
      input  end_of_packet,
      output ready
   );

endinterface

// ===== src/icrc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// icrc_rsp_if
// Result channel: raw CRC value of one finished packet.
// ----------------------------------------------------------------------------
interface icrc_rsp_if;
   import icrc_pkg::*;

   logic    valid;
   logic    ready;
   crc_type crc_value;

   modport source (
      output valid,
      output crc_value,
      input  ready
   );

   modport sink (
      input  valid,
      input  crc_value,
      output ready
   );

endinterface

// ===== src/icrc_lane.sv =====
// ----------------------------------------------------------------------------
// icrc_lane
// One byte lane: finds the byte's rank among the enabled bytes and registers
// its contribution to the crc at the end of the word.
// ----------------------------------------------------------------------------
module icrc_lane #(
   parameter int LANE = 0
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic [icrc_pkg::BYTE_BITS-1:0] data_byte,
   input  icrc_pkg::enable_type           byte_enable,
   output icrc_pkg::crc_type              contrib
);
   import icrc_pkg::*;

   count_type rank;
   count_type total;
   count_type pos;
   crc_type   contrib_in;
   crc_type   contrib_ff;

   always_comb begin
      rank  = '0;
      total = '0;
      for (int j = 0; j < LANES; j++) begin
         if (byte_enable[j]) begin
            total = total + count_type'(1);
            if (j <= LANE) begin
               rank = rank + count_type'(1);
            end
         end
      end
      // number of byte steps this byte still goes through
      pos = total - rank + count_type'(1);
      if (byte_enable[LANE]) begin
         contrib_in = crc_shift({{(CRC_BITS - BYTE_BITS){1'b0}}, data_byte}, pos);
      end else begin
         contrib_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         contrib_ff <= contrib_in;
      end
   end

   assign contrib = contrib_ff;

endmodule

// ===== src/icrc_merge.sv =====
// ----------------------------------------------------------------------------
// icrc_merge
// Merge stage: combines the lane contributions with the running crc and
// holds the finished value in the result register.
// ----------------------------------------------------------------------------
module icrc_merge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  icrc_pkg::icrc_ctl_type                   ctl,
   input  logic [icrc_pkg::LANES-1:0][icrc_pkg::CRC_BITS-1:0] contrib,
   output logic                                     out_free,
   icrc_rsp_if.source                               rsp_chan
);
   import icrc_pkg::*;

   crc_type crc_ff;
   crc_type crc_in;
   crc_type crc_next;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   crc_type rsp_crc_ff;
   crc_type rsp_crc_in;

   always_comb begin
      crc_next = crc_shift(crc_ff, ctl.count);
      for (int k = 0; k < LANES; k++) begin
         crc_next = crc_next ^ contrib[k];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_crc_in   = rsp_crc_ff;
      if (ctl.fire) begin
         if (ctl.last) begin
            crc_in       = CRC_START;
            rsp_valid_in = 1'b1;
            rsp_crc_in   = crc_next;
         end else begin
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.crc_value = rsp_crc_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.fire && ctl.last |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("pending result overwritten");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      ctl.fire && ctl.last |=> rsp_valid_ff)
      else $error("finished packet gave no result");

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.fire && ctl.last |=> crc_ff == CRC_START)
      else $error("crc not restarted after packet end");
`endif

endmodule

// ===== src/rocev2_icrc_calc_unit.sv =====
// ----------------------------------------------------------------------------
// rocev2_icrc_calc_unit
// RoCEv2 invariant CRC: masks the invariant header fields and folds every
// enabled byte into a reflected CRC-32, giving the raw register per packet.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    data_bytes[63:0] byte_enable[7:0] end_of_packet
//   rsp_chan   out   valid/ready    crc_value[31:0]
//
// one word transaction per cycle sustained, unless a last word waits on a pending
// result; the eight byte lanes and the merge stage with its crc feedback register are the registered stages
// the result is registered in the merge stage once the last word leaves the lanes
// reset (synchronous) clears the pipeline and loads the crc start value
// a waiting result stalls the input only when another last word reaches
// the merge stage
// ----------------------------------------------------------------------------
module rocev2_icrc_calc_unit #(
   parameter int HEADER_BITS = icrc_pkg::HEADER_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   icrc_req_if.sink   req_chan,
   icrc_rsp_if.source rsp_chan
);
   import icrc_pkg::*;

   logic                          req_fire;
   logic                          b_fire;
   logic                          out_free;
   word_type                      masked;
   count_type                     count;
   index_type                     hdr_idx_ff;
   index_type                     hdr_idx_in;
   logic                          a_valid_ff;
   logic                          a_valid_in;
   logic                          a_last_ff;
   count_type                     a_count_ff;
   logic [LANES-1:0][CRC_BITS-1:0] contrib;
   icrc_ctl_type                  ctl;

   assign b_fire         = a_valid_ff && (!a_last_ff || out_free);
   assign req_chan.ready = !a_valid_ff || b_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign masked = req_chan.data_bytes | header_mask(hdr_idx_ff, HEADER_BITS);

   always_comb begin
      count = '0;
      for (int j = 0; j < LANES; j++) begin
         if (req_chan.byte_enable[j]) begin
            count = count + count_type'(1);
         end
      end
   end

   always_comb begin
      hdr_idx_in = hdr_idx_ff;
      if (req_fire) begin
         if (req_chan.end_of_packet) begin
            hdr_idx_in = '0;
         end else if (hdr_idx_ff != IDX_MAX) begin
            hdr_idx_in = hdr_idx_ff + index_type'(1);
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (b_fire) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         hdr_idx_ff <= hdr_idx_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_last_ff  <= req_chan.end_of_packet;
         a_count_ff <= count;
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      icrc_lane #(
         .LANE (k)
      ) u_lane (
         .clock       (clock),
         .load        (req_fire),
         .data_byte   (masked[k*BYTE_BITS +: BYTE_BITS]),
         .byte_enable (req_chan.byte_enable),
         .contrib     (contrib[k])
      );
   end

   assign ctl.fire  = b_fire;
   assign ctl.last  = a_last_ff;
   assign ctl.count = a_count_ff;

   icrc_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .contrib  (contrib),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.end_of_packet |=> hdr_idx_ff == '0)
      else $error("header index not cleared at packet end");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_fire |=> a_valid_ff && $stable(a_last_ff) && $stable(a_count_ff))
      else $error("blocked lane stage lost its transaction");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> a_count_ff <= count_type'(LANES))
      else $error("enabled byte count out of range");
`endif

endmodule
